// ----- rtl/pscvt_pkg.sv -----
// Shared types and constants for the PCM sample format converter.
// No dependencies; every rtl file refers to it by scoped names.
`timescale 1ns / 1ps

package pscvt_pkg;

  // Divider geometry: 24-bit significands, 26 quotient bits (24 + guard + 1 extra)
  localparam int SIG_W     = 24;
  localparam int REM_W     = 25;
  localparam int QUO_W     = 26;
  localparam int DIV_CELLS = 26;

  // Register map (index = paddr[3:2])
  localparam logic [1:0] REG_BITS  = 2'd0;
  localparam logic [1:0] REG_BYTES = 2'd1;
  localparam logic [1:0] REG_FMODE = 2'd2;

  // What an item still needs when it leaves the front end
  typedef enum logic [1:0] {
    K_RAW,   // word is the final raw result
    K_FLT,   // word is the final float result
    K_PLAY,  // float-to-int: mant/expo still need the integer shift
    K_DIV    // int-to-float: quotient comes from the divider cells
  } kind_t;

  // Item payload carried alongside the divider data
  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
    logic        sgn;
    logic        nan;
    logic        inf;
    logic        zero;
    logic [24:0] mant;
    logic [9:0]  expo;   // two's complement
  } side_t;

  // Decoded configuration shared by all stages
  typedef struct packed {
    logic [4:0]  m;        // effective sample bits - 1
    logic        pow2;     // full scale rounds to 2^m in single precision
    logic [2:0]  nbytes;   // effective container bytes, 1..4
    logic [31:0] mask;     // container byte mask
    logic        fmode;
    logic [23:0] divisor;  // (2^m - 1) normalized to 24 bits
  } cfg_t;

endpackage

// ----- rtl/pscvt_front.sv -----
// Front end: two elastic stages that decode an item, scale a playback sample
// and normalize/round a capture sample. Depends on pscvt_pkg.
`timescale 1ns / 1ps

module pscvt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  pscvt_pkg::cfg_t   cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic              up_cmd,
  input  logic [31:0]       up_float,
  input  logic [31:0]       up_raw,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [24:0]       dn_rem,
  output pscvt_pkg::side_t  dn_side
);

  function automatic logic [2:0] lzc8(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 3'(7 - i);
    end
    return n;
  endfunction

  // ---------------- stage 1 ----------------
  logic                  s1_valid_r;
  pscvt_pkg::kind_t      s1_kind_r, s1_kind_nxt;
  logic [31:0]           s1_word_r, s1_word_nxt;
  logic [47:0]           s1_prod_r, s1_prod_nxt;
  logic [7:0]            s1_ex_r;
  logic                  s1_sgn_r, s1_sgn_nxt;
  logic                  s1_nan_r, s1_inf_r, s1_zero_r, s1_zero_nxt;
  logic                  s1_pow_r, s1_pow_nxt;
  logic [1:0]            s1_cnt_r, s1_cnt_nxt;
  logic                  s1_en, s2_en;

  logic [7:0]  ex_c;
  logic [23:0] sc_c;
  logic [31:0] v_c, sx_c, mag_c;
  logic        vsgn_c;

  always_comb begin
    ex_c        = up_float[30:23];
    s1_pow_nxt  = cfg.pow2 | up_float[31];
    sc_c        = s1_pow_nxt ? 24'd1 : 24'((25'd1 << cfg.m) - 25'd1);
    // 24 x 24 significand product
    s1_prod_nxt = 48'({1'b1, up_float[22:0]}) * 48'(sc_c);

    v_c = up_raw & cfg.mask;
    case (cfg.nbytes)
      3'd1:    vsgn_c = v_c[7];
      3'd2:    vsgn_c = v_c[15];
      3'd3:    vsgn_c = v_c[23];
      default: vsgn_c = v_c[31];
    endcase
    sx_c  = vsgn_c ? (v_c | ~cfg.mask) : v_c;
    mag_c = vsgn_c ? (~sx_c + 32'd1) : sx_c;

    // coarse normalize by whole bytes
    if (mag_c[31:24] != 8'd0)      s1_cnt_nxt = 2'd0;
    else if (mag_c[23:16] != 8'd0) s1_cnt_nxt = 2'd1;
    else if (mag_c[15:8] != 8'd0)  s1_cnt_nxt = 2'd2;
    else                           s1_cnt_nxt = 2'd3;

    s1_sgn_nxt  = up_cmd ? vsgn_c : up_float[31];
    s1_zero_nxt = up_cmd ? (mag_c == 32'd0) : (ex_c == 8'd0);

    if (!up_cmd) begin
      s1_kind_nxt = cfg.fmode ? pscvt_pkg::K_RAW : pscvt_pkg::K_PLAY;
      s1_word_nxt = up_float & cfg.mask;
    end else begin
      s1_kind_nxt = cfg.fmode ? pscvt_pkg::K_FLT : pscvt_pkg::K_DIV;
      s1_word_nxt = cfg.fmode ? v_c : (mag_c << {s1_cnt_nxt, 3'b000});
    end
  end

  assign s1_en    = !s1_valid_r || s2_en;
  assign up_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && up_valid) begin
      s1_kind_r <= s1_kind_nxt;
      s1_word_r <= s1_word_nxt;
      s1_prod_r <= s1_prod_nxt;
      s1_ex_r   <= ex_c;
      s1_sgn_r  <= s1_sgn_nxt;
      s1_nan_r  <= (ex_c == 8'hFF) && (up_float[22:0] != 23'd0);
      s1_inf_r  <= (ex_c == 8'hFF) && (up_float[22:0] == 23'd0);
      s1_zero_r <= s1_zero_nxt;
      s1_pow_r  <= s1_pow_nxt;
      s1_cnt_r  <= s1_cnt_nxt;
    end
  end

  // ---------------- stage 2 ----------------
  logic              s2_valid_r;
  pscvt_pkg::side_t  s2_side_r, s2_side_nxt;
  logic [24:0]       s2_rem_r, s2_rem_nxt;

  logic [4:0]  k_c, sexp_c, p_c;
  logic [5:0]  km1_c;
  logic [5:0]  lead_c, p1_c;
  logic [47:0] qs_c, stmask_c;
  logic        grd_c, stk_c;
  logic [2:0]  lz8_c;
  logic [31:0] a_c;
  logic [24:0] f_c;
  logic [23:0] fn_c;
  logic [9:0]  bexp_c;

  always_comb begin
    s2_side_nxt      = '0;
    s2_side_nxt.kind = s1_kind_r;
    s2_side_nxt.word = s1_word_r;
    s2_side_nxt.sgn  = s1_sgn_r;
    s2_side_nxt.nan  = s1_nan_r;
    s2_side_nxt.inf  = s1_inf_r;
    s2_side_nxt.zero = s1_zero_r;
    s2_rem_nxt       = '0;

    // playback: round the product to 24 significant bits
    lead_c = 6'(cfg.m) + 6'd23;
    if (s1_pow_r) begin
      k_c    = 5'd0;
      sexp_c = cfg.m;
    end else begin
      k_c    = s1_prod_r[lead_c] ? cfg.m : (cfg.m - 5'd1);
      sexp_c = 5'd0;
    end
    km1_c    = 6'(k_c) - 6'd1;
    qs_c     = s1_prod_r >> k_c;
    stmask_c = (48'd1 << km1_c) - 48'd1;
    grd_c    = (k_c != 5'd0) && s1_prod_r[km1_c];
    stk_c    = (k_c != 5'd0) && ((s1_prod_r & stmask_c) != 48'd0);

    // capture: fine normalize and round to single precision
    lz8_c  = lzc8(s1_word_r[31:24]);
    a_c    = s1_word_r << lz8_c;
    p_c    = 5'd31 - ({s1_cnt_r, 3'b000} + 5'(lz8_c));
    f_c    = {1'b0, a_c[31:8]} + 25'(a_c[7] & ((a_c[6:0] != 7'd0) | a_c[8]));
    if (f_c[24]) begin
      fn_c = 24'h800000;
      p1_c = 6'(p_c) + 6'd1;
    end else begin
      fn_c = f_c[23:0];
      p1_c = 6'(p_c);
    end
    bexp_c = 10'(p1_c) - 10'(cfg.m) + 10'd127;

    case (s1_kind_r)
      pscvt_pkg::K_PLAY: begin
        s2_side_nxt.mant = {1'b0, qs_c[23:0]} + 25'(grd_c & (stk_c | qs_c[0]));
        s2_side_nxt.expo = 10'(k_c) + 10'(s1_ex_r) + 10'(sexp_c) - 10'd150;
      end
      pscvt_pkg::K_DIV: begin
        if (s1_zero_r) begin
          s2_side_nxt.kind = pscvt_pkg::K_FLT;
          s2_side_nxt.word = 32'd0;
        end else if (cfg.pow2) begin
          // division by a power of two is exact
          s2_side_nxt.kind = pscvt_pkg::K_FLT;
          s2_side_nxt.word = {s1_sgn_r, bexp_c[7:0], fn_c[22:0]};
        end else begin
          s2_side_nxt.expo = 10'(p1_c) - 10'(cfg.m);
          s2_rem_nxt       = {1'b0, fn_c};
        end
      end
      default: ;
    endcase
  end

  assign s2_en    = !s2_valid_r || dn_ready;
  assign dn_valid = s2_valid_r;
  assign dn_side  = s2_side_r;
  assign dn_rem   = s2_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      s2_side_r <= s2_side_nxt;
      s2_rem_r  <= s2_rem_nxt;
    end
  end

endmodule

// ----- rtl/pscvt_div_cell.sv -----
// One restoring-division cell: one quotient bit per cell, elastic register.
// Depends on pscvt_pkg.
`timescale 1ns / 1ps

module pscvt_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [23:0]       divisor,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [24:0]       up_rem,
  input  logic [25:0]       up_quo,
  input  pscvt_pkg::side_t  up_side,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [24:0]       dn_rem,
  output logic [25:0]       dn_quo,
  output pscvt_pkg::side_t  dn_side
);

  logic              valid_r;
  logic [24:0]       rem_r, rem_nxt;
  logic [25:0]       quo_r, quo_nxt;
  pscvt_pkg::side_t  side_r;
  logic              en, ge;
  logic [24:0]       diff;

  // compare-subtract, then shift the partial remainder
  always_comb begin
    ge      = up_rem >= {1'b0, divisor};
    diff    = ge ? (up_rem - {1'b0, divisor}) : up_rem;
    rem_nxt = {diff[23:0], 1'b0};
    quo_nxt = {up_quo[24:0], ge};
  end

  assign en       = !valid_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_quo   = quo_r;
  assign dn_side  = side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      side_r <= up_side;
    end
  end

endmodule

// ----- rtl/pscvt_back.sv -----
// Output stage: finishes float-to-int shift/saturation and quotient rounding,
// and holds the result item. Depends on pscvt_pkg.
`timescale 1ns / 1ps

module pscvt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pscvt_pkg::cfg_t   cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [24:0]       up_rem,
  input  logic [25:0]       up_quo,
  input  pscvt_pkg::side_t  up_side,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_raw,
  output logic [31:0]       out_float,
  output logic              out_clipped
);

  logic        valid_r;
  logic [31:0] raw_r, raw_nxt, flt_r, flt_nxt;
  logic        clip_r, clip_nxt;
  logic        en;

  logic [9:0]  ne_c, e_c;
  logic [33:0] mag_c;
  logic [31:0] res_c;
  logic [23:0] sig_c;
  logic        g_c, st_c;
  logic [24:0] rs_c;

  always_comb begin
    raw_nxt  = 32'd0;
    flt_nxt  = 32'd0;
    clip_nxt = 1'b0;
    res_c    = 32'd0;
    mag_c    = 34'd0;
    ne_c     = ~up_side.expo + 10'd1;
    e_c      = up_side.expo;

    // quotient rounding (round to nearest even)
    if (up_quo[25]) begin
      sig_c = up_quo[25:2];
      g_c   = up_quo[1];
      st_c  = up_quo[0] | (up_rem != 25'd0);
      e_c   = up_side.expo + 10'd1;
    end else begin
      sig_c = up_quo[24:1];
      g_c   = up_quo[0];
      st_c  = up_rem != 25'd0;
    end
    rs_c = {1'b0, sig_c} + 25'(g_c & (st_c | sig_c[0]));
    if (rs_c[24]) e_c = e_c + 10'd1;
    e_c = e_c + 10'd127;

    // integer magnitude of the rounded product, truncated toward zero
    if (!up_side.expo[9]) begin
      mag_c = 34'(up_side.mant) << up_side.expo[3:0];
    end else begin
      mag_c = 34'(up_side.mant) >> ne_c[4:0];
    end

    case (up_side.kind)
      pscvt_pkg::K_RAW: raw_nxt = up_side.word;
      pscvt_pkg::K_FLT: flt_nxt = up_side.word;
      pscvt_pkg::K_PLAY: begin
        if (up_side.nan) begin
          clip_nxt = 1'b1;
        end else if (up_side.zero) begin
          res_c = 32'd0;
        end else if (up_side.inf || ($signed(up_side.expo) > 10'sd8)) begin
          res_c    = up_side.sgn ? 32'h80000000 : 32'h7FFFFFFF;
          clip_nxt = 1'b1;
        end else if ($signed(up_side.expo) < -10'sd25) begin
          res_c = 32'd0;
        end else if (!up_side.sgn) begin
          if (mag_c >= 34'h080000000) begin
            res_c    = 32'h7FFFFFFF;
            clip_nxt = 1'b1;
          end else begin
            res_c = mag_c[31:0];
          end
        end else begin
          if (mag_c > 34'h080000000) begin
            res_c    = 32'h80000000;
            clip_nxt = 1'b1;
          end else begin
            res_c = ~mag_c[31:0] + 32'd1;
          end
        end
        raw_nxt = res_c & cfg.mask;
      end
      pscvt_pkg::K_DIV: flt_nxt = {up_side.sgn, e_c[7:0], rs_c[22:0]};
      default: ;
    endcase
  end

  assign en          = !valid_r || !out_stall;
  assign up_ready    = en;
  assign out_valid   = valid_r;
  assign out_raw     = raw_r;
  assign out_float   = flt_r;
  assign out_clipped = clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      raw_r  <= raw_nxt;
      flt_r  <= flt_nxt;
      clip_r <= clip_nxt;
    end
  end

endmodule

// ----- rtl/pcm_sample_format_converter_core.sv -----
// Top level of the PCM sample format converter: config registers, front end,
// divider cell row and output stage. Depends on pscvt_pkg and all rtl modules.
`timescale 1ns / 1ps

// Converts one audio sample per item between IEEE single float and a signed
// little-endian PCM word held in the low container bytes. Every item, in
// either direction, runs through the same 29-stage elastic pipeline: two
// front stages, a row of 26 divider cells that each resolve one quotient
// bit of the capture-direction division by full scale, and the output
// register. One item is accepted every cycle when nothing stalls; a stalled
// output only holds back items that reach a full stage, so bubbles are
// absorbed. The user writes configuration through the APB port while idle; unenforced.

module pcm_sample_format_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_float,
  input  logic [31:0] in_raw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_raw,
  output logic [31:0] out_float,
  output logic        out_clipped
);

  localparam int N = pscvt_pkg::DIV_CELLS;

  // ---------------- configuration registers ----------------
  logic [5:0] sb_r;
  logic [2:0] cb_r;
  logic       fm_r;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r <= 6'd16;
      cb_r <= 3'd2;
      fm_r <= 1'b0;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        pscvt_pkg::REG_BITS:  sb_r <= cfg_pwdata[5:0];
        pscvt_pkg::REG_BYTES: cb_r <= cfg_pwdata[2:0];
        pscvt_pkg::REG_FMODE: fm_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      pscvt_pkg::REG_BITS:  cfg_prdata = {26'd0, sb_r};
      pscvt_pkg::REG_BYTES: cfg_prdata = {29'd0, cb_r};
      pscvt_pkg::REG_FMODE: cfg_prdata = {31'd0, fm_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- decoded configuration ----------------
  pscvt_pkg::cfg_t cfg;
  logic [5:0]      eb;

  always_comb begin
    if (sb_r < 6'd8)       eb = 6'd8;
    else if (sb_r > 6'd32) eb = 6'd32;
    else                   eb = sb_r;
    cfg.m     = 5'(eb - 6'd1);
    // 2^m - 1 still fits a 24-bit significand up to m = 24
    cfg.pow2  = eb >= 6'd26;
    cfg.fmode = fm_r;
    if (cb_r < 3'd1)      cfg.nbytes = 3'd1;
    else if (cb_r > 3'd4) cfg.nbytes = 3'd4;
    else                  cfg.nbytes = cb_r;
    case (cfg.nbytes)
      3'd1:    cfg.mask = 32'h000000FF;
      3'd2:    cfg.mask = 32'h0000FFFF;
      3'd3:    cfg.mask = 32'h00FFFFFF;
      default: cfg.mask = 32'hFFFFFFFF;
    endcase
    cfg.divisor = 24'(((32'd1 << cfg.m) - 32'd1) << (5'd24 - cfg.m));
  end

  // ---------------- datapath ----------------
  logic             vld_w [0:N];
  logic             rdy_w [0:N];
  logic [24:0]      rem_w [0:N];
  logic [25:0]      quo_w [0:N];
  pscvt_pkg::side_t side_w [0:N];
  logic             front_ready;

  assign in_stall = !front_ready;
  assign quo_w[0] = '0;

  pscvt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .up_cmd   (in_cmd),
    .up_float (in_float),
    .up_raw   (in_raw),
    .dn_valid (vld_w[0]),
    .dn_ready (rdy_w[0]),
    .dn_rem   (rem_w[0]),
    .dn_side  (side_w[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    pscvt_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .divisor  (cfg.divisor),
      .up_valid (vld_w[g]),
      .up_ready (rdy_w[g]),
      .up_rem   (rem_w[g]),
      .up_quo   (quo_w[g]),
      .up_side  (side_w[g]),
      .dn_valid (vld_w[g+1]),
      .dn_ready (rdy_w[g+1]),
      .dn_rem   (rem_w[g+1]),
      .dn_quo   (quo_w[g+1]),
      .dn_side  (side_w[g+1])
    );
  end

  pscvt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .up_valid    (vld_w[N]),
    .up_ready    (rdy_w[N]),
    .up_rem      (rem_w[N]),
    .up_quo      (quo_w[N]),
    .up_side     (side_w[N]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_raw     (out_raw),
    .out_float   (out_float),
    .out_clipped (out_clipped)
  );

`ifndef SYNTH
  // raw results never carry bits above the container
  a_raw_in_container: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_raw & ~cfg.mask) == 32'd0))
    else $error("raw result has bits above the container");

  // a clipped item comes from the playback direction
  a_clip_playback: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |-> (out_float == 32'd0))
    else $error("clipped set on a capture item");

  // only one of the two result words is populated
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_float != 32'd0)) |-> (out_raw == 32'd0))
    else $error("both result words nonzero");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for pcm_sample_format_converter_core. Needs pscvt_pkg.
// Drives samples in both directions over several register settings and checks
// each result against a given value or a bit-exact integer model of float arithmetic.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_WAIT   = 40;
  localparam int N_PHASES     = 11;
  localparam int PHASE_ITEMS  = 67;

  typedef struct {
    logic [31:0] raw;
    logic [31:0] flt;
    logic        clip;
  } sample_res_t;

  typedef struct {
    logic        cmd;
    logic [31:0] flt;
    logic [31:0] raw;
    bit          typed;   // expected result given in the row
    sample_res_t res;
  } stim_row_t;

  typedef struct {
    logic [31:0] bits;
    logic [31:0] bytes;
    logic [31:0] fmode;
  } setting_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid = 1'b0, in_cmd = 1'b0;
  logic [31:0] in_float = '0, in_raw = '0;
  logic        in_stall;
  logic        out_valid, out_stall = 1'b0, out_clipped;
  logic [31:0] out_raw, out_float;

  // Shadow copies of the registers
  logic [5:0]  sh_bits = 6'd16;
  logic [2:0]  sh_bytes = 3'd2;
  logic        sh_fmode = 1'b0;

  sample_res_t pending_q[$];
  int          n_errors = 0;
  int          n_checked = 0;
  int          n_sent = 0;
  int          n_clipped = 0;
  int          cycle_cnt = 0;
  bit          idle_en = 1'b1;
  int          hold_req = 0;

  stim_row_t   rows[$];
  setting_t    phases[N_PHASES];

  pcm_sample_format_converter_core i_dut (.*);

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[pcm_sample_format_converter_core] ERROR");
      $finish;
    end
  end

  // Round a nonzero magnitude to a 24-bit significand, nearest even.
  // q lies in [2^23, 2^24); value is q * 2^sh. sticky marks lost low bits.
  function automatic void round_sig24(input logic [63:0] p, input bit sticky,
                                      output logic [24:0] q, output int sh);
    int len;
    logic [63:0] rem, half;
    len = 0;
    for (int i = 0; i < 64; i++) if (p[i]) len = i + 1;
    if (len <= 24) begin
      q = 25'(p << (24 - len));
      sh = len - 24;
    end else begin
      sh = len - 24;
      q = 25'(p >> sh);
      rem = p & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && (sticky || q[0]))) q = q + 1;
      if (q[24]) begin
        q = q >> 1;
        sh = sh + 1;
      end
    end
  endfunction

  // Expected result of one sample under the shadow registers
  function automatic sample_res_t convert_sample(logic cmd, logic [31:0] fb,
                                                 logic [31:0] rw);
    sample_res_t r;
    int m, nbytes, sh, t, sha, shf, e;
    logic [31:0] mask, res;
    logic [63:0] full_int, scale, prod, mag, num, quo, remd;
    logic [24:0] q, qa, qf;
    bit big, neg;
    r = '{raw: '0, flt: '0, clip: 1'b0};
    m = (sh_bits < 8) ? 7 : (sh_bits > 32) ? 31 : int'(sh_bits) - 1;
    nbytes = (sh_bytes < 1) ? 1 : (sh_bytes > 4) ? 4 : int'(sh_bytes);
    mask = (nbytes == 4) ? 32'hFFFF_FFFF : (32'd1 << (8 * nbytes)) - 1;
    full_int = (64'd1 << m) - 1;
    if (cmd == 1'b0) begin
      res = '0;
      if (sh_fmode) begin
        res = fb;
      end else if (fb[30:23] == 8'hFF && fb[22:0] != 0) begin
        r.clip = 1'b1;
      end else if (fb[30:23] == 8'hFF) begin
        res = fb[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        r.clip = 1'b1;
      end else if (fb[30:0] != 0) begin
        // Negative samples scale by 2^m, positive by full scale as a float
        if (fb[31]) scale = 64'd1 << m;
        else scale = (m <= 24) ? full_int : (64'd1 << m);
        prod = (fb[30:23] == 0) ? {41'd0, fb[22:0]} : {40'd0, 1'b1, fb[22:0]};
        e = (fb[30:23] == 0) ? -149 : int'(fb[30:23]) - 150;
        prod = prod * scale;
        round_sig24(prod, 1'b0, q, sh);
        t = sh + e;
        big = (t >= 32);
        if (big) mag = '0;
        else if (t >= 0) mag = 64'(q) << t;
        else if (t > -64) mag = 64'(q) >> (-t);
        else mag = '0;
        if (!fb[31]) begin
          if (big || mag >= 64'h8000_0000) begin
            res = 32'h7FFF_FFFF;
            r.clip = 1'b1;
          end else res = mag[31:0];
        end else begin
          if (big || mag > 64'h8000_0000) begin
            res = 32'h8000_0000;
            r.clip = 1'b1;
          end else res = 32'(-mag);
        end
      end
      r.raw = res & mask;
    end else begin
      res = rw & mask;
      if (sh_fmode) begin
        r.flt = res;
      end else if (res != 0) begin
        neg = res[8 * nbytes - 1];
        mag = neg ? ((64'd1 << (8 * nbytes)) - 64'(res)) : 64'(res);
        round_sig24(mag, 1'b0, qa, sha);
        round_sig24(full_int, 1'b0, qf, shf);
        num = 64'(qa) << 27;
        quo = num / 64'(qf);
        remd = num % 64'(qf);
        round_sig24(quo, remd != 0, q, sh);
        e = sha - shf - 27 + sh + 23 + 127;
        r.flt = {neg, e[7:0], q[22:0]};
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("MISMATCH at %0t: %s got %08h expected %08h", $realtime, what, got, want);
  endtask

  // Result checker
  always @(posedge clk) begin
    sample_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected item, raw", out_raw, 32'h0);
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (out_clipped) n_clipped++;
        if (out_raw !== want.raw) report_mismatch("out_raw", out_raw, want.raw);
        if (out_float !== want.flt) report_mismatch("out_float", out_float, want.flt);
        if (out_clipped !== want.clip)
          report_mismatch("out_clipped", 32'(out_clipped), 32'(want.clip));
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        hold_req = hold_req - 1;
      end else if (burst > 0) begin
        burst--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 16) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      pscvt_pkg::REG_BITS:  sh_bits = val[5:0];
      pscvt_pkg::REG_BYTES: sh_bytes = val[2:0];
      pscvt_pkg::REG_FMODE: sh_fmode = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Offer one item, wait for acceptance, then record what it must produce
  task automatic send_sample(logic cmd, logic [31:0] fb, logic [31:0] rw,
                             bit typed, sample_res_t res);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_float <= fb;
    in_raw <= rw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(typed ? res : convert_sample(cmd, fb, rw));
    n_sent++;
  endtask

  function automatic logic [31:0] pick_float();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 7))
          0: v = 32'h7FC0_0000;
          1: v = 32'hFF80_0000;
          2: v = 32'h7F80_0000;
          3: v = 32'h8000_0000;
          4: v = 32'h0000_0001;
          5: v = 32'hBF80_0000;
          6: v = 32'h3F80_0000;
          default: v = 32'h7F7F_FFFF;
        endcase
      end
      default: v = {1'($urandom), 8'($urandom_range(100, 130)), 23'($urandom)};
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_raw();
    logic [31:0] v;
    if ($urandom_range(0, 4) != 0) begin
      v = $urandom;
    end else begin
      v = 32'h1 << $urandom_range(0, 31);
      if ($urandom_range(0, 1)) v = v - 1;
      if ($urandom_range(0, 1)) v = ~v;
    end
    return v;
  endfunction

  function automatic stim_row_t mk_row(logic cmd, logic [31:0] fb, logic [31:0] rw,
                                       bit typed, logic [31:0] xr, logic [31:0] xf,
                                       logic xc);
    stim_row_t s;
    s.cmd = cmd;
    s.flt = fb;
    s.raw = rw;
    s.typed = typed;
    s.res = '{raw: xr, flt: xf, clip: xc};
    return s;
  endfunction

  initial begin
    sample_res_t none;
    none = '{raw: '0, flt: '0, clip: 1'b0};

    // Directed rows, reset setting: 16-bit samples in 2-byte containers
    rows.push_back(mk_row(1'b0, 32'h3F80_0000, 32'h0, 1, 32'h7FFF, 32'h0, 1'b0));
    rows.push_back(mk_row(1'b0, 32'hBF80_0000, 32'h0, 1, 32'h8000, 32'h0, 1'b0));
    rows.push_back(mk_row(1'b0, 32'h0000_0000, 32'h0, 1, 32'h0, 32'h0, 1'b0));
    rows.push_back(mk_row(1'b0, 32'h8000_0000, 32'h0, 1, 32'h0, 32'h0, 1'b0));
    rows.push_back(mk_row(1'b0, 32'h7FC0_0000, 32'h0, 1, 32'h0, 32'h0, 1'b1));
    rows.push_back(mk_row(1'b0, 32'hFFC0_0001, 32'h0, 1, 32'h0, 32'h0, 1'b1));
    rows.push_back(mk_row(1'b0, 32'h7F80_0000, 32'h0, 1, 32'hFFFF, 32'h0, 1'b1));
    rows.push_back(mk_row(1'b0, 32'hFF80_0000, 32'h0, 1, 32'h0, 32'h0, 1'b1));
    rows.push_back(mk_row(1'b0, 32'h7F7F_FFFF, 32'h0, 1, 32'hFFFF, 32'h0, 1'b1));
    rows.push_back(mk_row(1'b0, 32'hFF7F_FFFF, 32'h0, 1, 32'h0, 32'h0, 1'b1));
    rows.push_back(mk_row(1'b0, 32'h4000_0000, 32'h0, 1, 32'hFFFE, 32'h0, 1'b0));
    rows.push_back(mk_row(1'b0, 32'h0000_0001, 32'h0, 1, 32'h0, 32'h0, 1'b0));
    rows.push_back(mk_row(1'b0, 32'h3F00_0000, 32'h0, 0, 32'h0, 32'h0, 1'b0));
    rows.push_back(mk_row(1'b1, 32'h0, 32'h0000_7FFF, 1, 32'h0, 32'h3F80_0000, 1'b0));
    rows.push_back(mk_row(1'b1, 32'h0, 32'h1234_7FFF, 1, 32'h0, 32'h3F80_0000, 1'b0));
    rows.push_back(mk_row(1'b1, 32'h0, 32'hFFFF_0000, 1, 32'h0, 32'h0, 1'b0));
    rows.push_back(mk_row(1'b1, 32'h0, 32'h0000_8000, 0, 32'h0, 32'h0, 1'b0));
    rows.push_back(mk_row(1'b1, 32'h0, 32'hFFFF_FFFF, 0, 32'h0, 32'h0, 1'b0));
    rows.push_back(mk_row(1'b1, 32'h0, 32'h0000_0001, 0, 32'h0, 32'h0, 1'b0));

    // Register settings per phase, out-of-range values and float mode included
    phases[0]  = '{32'd8,  32'd1, 32'd0};
    phases[1]  = '{32'd32, 32'd4, 32'd0};
    phases[2]  = '{32'd24, 32'd3, 32'd0};
    phases[3]  = '{32'd16, 32'd2, 32'd0};
    phases[4]  = '{32'd0,  32'd0, 32'd0};
    phases[5]  = '{32'hFFFF_FFFF, 32'd7, 32'd0};
    phases[6]  = '{32'd16, 32'd4, 32'd1};
    phases[7]  = '{32'd25, 32'd4, 32'd0};
    phases[8]  = '{32'd32, 32'd1, 32'hFFFF_FFFE};
    phases[9]  = '{32'd8,  32'd3, 32'd1};
    phases[10] = '{32'd31, 32'd4, 32'd0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    foreach (rows[i]) send_sample(rows[i].cmd, rows[i].flt, rows[i].raw,
                                  rows[i].typed, rows[i].res);
    in_valid <= 1'b0;

    // Random phases, registers rewritten while idle
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drain();
      write_reg(pscvt_pkg::REG_BITS, phases[p].bits);
      write_reg(pscvt_pkg::REG_BYTES, phases[p].bytes);
      write_reg(pscvt_pkg::REG_FMODE, phases[p].fmode);
      if (p == 3) hold_req = 300;            // receiver backs up the pipeline
      if (p == N_PHASES - 1) idle_en = 1'b0; // full rate at the end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 6 && k == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 1)) send_sample(1'b0, pick_float(), $urandom, 0, none);
        else send_sample(1'b1, $urandom, pick_raw(), 0, none);
      end
      in_valid <= 1'b0;
    end

    wait_drain();
    $display("covered %0d items over %0d register settings in both directions",
             n_sent, N_PHASES + 1);
    $display("%0d results checked, %0d clipped, %0d mismatches",
             n_checked, n_clipped, n_errors);
    if (n_errors == 0) begin
      $display("[pcm_sample_format_converter_core] OK");
    end else begin
      $display("[pcm_sample_format_converter_core] ERROR");
    end
    $finish;
  end

endmodule
